FILE: rtl/tile_atlas_palette_builder_unit_defines.svh
// assertion macros for the tile atlas palette builder
`ifndef TILE_ATLAS_PALETTE_BUILDER_UNIT_DEFINES_SVH
`define TILE_ATLAS_PALETTE_BUILDER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TAPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("label failed");

// next-cycle implication
`define TAPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("label failed");

`endif

FILE: rtl/tapb_pkg.sv
// ----------------------------------------------------------------------------
// tapb_pkg
// shared types and constants for the tile atlas palette builder
// ----------------------------------------------------------------------------
package tapb_pkg;

    localparam int MaxTiles       = 2048;
    localparam int PaletteEntries = 256;
    localparam int MaxTileSide    = 64;
    localparam int AcrossMax      = 2048;

    localparam int PalAw = (PaletteEntries > 1) ? $clog2(PaletteEntries) : 1;
    localparam int CntW  = PalAw + 1;
    localparam int SideW = $clog2(MaxTileSide);
    localparam int TdW   = 12;

    localparam logic [2:0] RegTransEnable = 3'd0;
    localparam logic [2:0] RegTransColor  = 3'd1;
    localparam logic [2:0] RegTilesAcross = 3'd2;
    localparam logic [2:0] RegTileWidth   = 3'd3;
    localparam logic [2:0] RegTileHeight  = 3'd4;

    // front to back queue entry
    typedef struct packed {
        logic [23:0] color;
        logic [24:0] byte_addr;
        logic [22:0] idx_addr;
        logic [7:0]  alpha;
        logic        tile_end;
        logic        limit;
        logic        ignored;
    } t_job;

    typedef struct packed {
        logic [24:0] pixel_byte_address;
        logic [7:0]  alpha;
        logic [22:0] index_address;
        logic [7:0]  palette_index;
        logic        index_valid;
        logic        palette_dropped;
        logic        new_color;
        logic        tile_end;
        logic        tile_limit_error;
    } t_result;

endpackage

FILE: rtl/tapb_ram.sv
// ----------------------------------------------------------------------------
// tapb_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module tapb_ram #(
    parameter int Width = 24,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/tapb_front.sv
// ----------------------------------------------------------------------------
// tapb_front
// accepts pixels, tracks tile position and works out addresses in the states
// S_M1 to S_M4; hands a job to the queue
// ----------------------------------------------------------------------------
module tapb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [23:0]        i_color,
    input  logic               i_trans_enable,
    input  logic [23:0]        i_trans_color,
    input  logic [11:0]        i_tiles_across,
    input  logic [6:0]         i_tile_width,
    input  logic [6:0]         i_tile_height,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output tapb_pkg::t_job     o_job
);
    typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_M3, S_M4, S_OUT} t_state;

    t_state r_state;
    logic [5:0]  r_col, r_row;
    logic [10:0] r_bx, r_by;
    logic [11:0] r_done;
    logic        r_limit;
    logic [6:0]  r_tw, r_th;
    logic [11:0] r_across;
    logic [5:0]  r_x, r_y;
    logic [10:0] r_cbx, r_cby;
    logic [23:0] r_rowv;
    logic [24:0] r_rowa;
    logic [24:0] r_idx;
    tapb_pkg::t_job r_job;

    logic [6:0]  w_tw, w_th;
    logic [11:0] w_across;
    logic        w_col_end, w_row_end, w_col_wrap;
    logic [11:0] w_bx_inc;
    logic [11:0] w_done_inc;
    logic [24:0] w_idxf;
    logic [26:0] w_bytef;

    always_comb begin
        w_tw = (i_tile_width == 7'd0) ? 7'd1 :
               (i_tile_width > 7'(tapb_pkg::MaxTileSide)) ?
               7'(tapb_pkg::MaxTileSide) : i_tile_width;
        w_th = (i_tile_height == 7'd0) ? 7'd1 :
               (i_tile_height > 7'(tapb_pkg::MaxTileSide)) ?
               7'(tapb_pkg::MaxTileSide) : i_tile_height;
        w_across = (i_tiles_across == 12'd0) ? 12'd1 :
                   (i_tiles_across > 12'(tapb_pkg::AcrossMax)) ?
                   12'(tapb_pkg::AcrossMax) : i_tiles_across;
        w_col_end  = ({1'b0, r_col} + 7'd1) >= w_tw;
        w_row_end  = ({1'b0, r_row} + 7'd1) >= w_th;
        w_bx_inc   = {1'b0, r_bx} + 12'd1;
        w_col_wrap = w_bx_inc >= w_across;
        w_done_inc = r_done + 12'd1;
        w_idxf     = r_rowa * 25'(r_tw) + 25'(r_x);
        w_bytef    = 27'(r_idx) * 27'd3;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_bx    <= '0;
            r_by    <= '0;
            r_done  <= '0;
            r_limit <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tw     <= w_tw;
                        r_th     <= w_th;
                        r_across <= w_across;
                        r_x      <= r_col;
                        r_y      <= r_row;
                        r_cbx    <= r_bx;
                        r_cby    <= r_by;
                        r_job.ignored <= r_limit;
                        r_job.tile_end <= !r_limit && w_col_end && w_row_end;
                        r_job.limit <= r_limit || (w_col_end && w_row_end &&
                                       w_done_inc >= 12'(tapb_pkg::MaxTiles));
                        r_job.color <= i_color;
                        r_job.alpha <= (i_trans_enable && i_color == i_trans_color)
                                       ? 8'd0 : 8'd255;
                        r_job.byte_addr <= '0;
                        r_job.idx_addr  <= '0;
                        if (r_limit) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_M1;
                            if (w_col_end) begin
                                r_col <= '0;
                                if (w_row_end) begin
                                    r_row <= '0;
                                    if (w_col_wrap) begin
                                        r_bx <= '0;
                                        r_by <= r_by + 11'd1;
                                    end else begin
                                        r_bx <= w_bx_inc[10:0];
                                    end
                                    r_done <= w_done_inc;
                                    if (w_done_inc >= 12'(tapb_pkg::MaxTiles)) begin
                                        r_limit <= 1'b1;
                                    end
                                end else begin
                                    r_row <= r_row + 6'd1;
                                end
                            end else begin
                                r_col <= r_col + 6'd1;
                            end
                        end
                    end
                end
                S_M1: begin
                    r_rowv  <= 24'(r_cby) * 24'(r_th) + 24'(r_y);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_rowa  <= 25'(r_rowv) * 25'(r_across) + 25'(r_cbx);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_idx   <= w_idxf;
                    r_job.idx_addr <= w_idxf[22:0];
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_job.byte_addr <= i_trans_enable ? {r_idx[22:0], 2'b00}
                                                      : w_bytef[24:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_job_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/tapb_queue.sv
// ----------------------------------------------------------------------------
// tapb_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module tapb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tapb_pkg::t_job i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output tapb_pkg::t_job o_data
);
    tapb_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

FILE: rtl/tapb_back.sv
// ----------------------------------------------------------------------------
// tapb_back
// palette search from the newest entry down, append and overflow handling
// ----------------------------------------------------------------------------
module tapb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_trans_enable,
    input  logic [23:0]         i_trans_color,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  tapb_pkg::t_job      i_job,
    output logic                o_valid,
    input  logic                i_ready,
    output tapb_pkg::t_result   o_result
);
    typedef enum logic [2:0] {S_IDLE, S_SEED, S_READ, S_CMP, S_DONE} t_state;

    t_state r_state;
    tapb_pkg::t_job r_job;
    logic [tapb_pkg::CntW-1:0] r_count, r_ptr;
    logic r_active, r_seeded;
    logic r_hit;
    logic r_valid;
    tapb_pkg::t_result r_res;
    tapb_pkg::t_result n_res;

    logic                        w_we;
    logic [tapb_pkg::PalAw-1:0]  w_addr;
    logic [23:0]                 w_wdata, w_rdata;
    logic                        w_room, w_append, w_overflow, w_out_free;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid     = r_valid;
    assign o_result    = r_res;

    always_comb begin
        w_out_free = !r_valid || i_ready;
        w_room     = r_count < tapb_pkg::CntW'(tapb_pkg::PaletteEntries);
        w_append   = !r_job.ignored && !r_hit && r_active && w_room;
        w_overflow = !r_job.ignored && !r_hit && r_active && !w_room;
    end

    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_ptr[tapb_pkg::PalAw-1:0] - tapb_pkg::PalAw'(1);
        w_wdata = r_job.color;
        if (r_state == S_SEED) begin
            w_we    = 1'b1;
            w_addr  = '0;
            w_wdata = i_trans_color;
        end else if (r_state == S_DONE && w_append && w_out_free) begin
            w_we   = 1'b1;
            w_addr = r_count[tapb_pkg::PalAw-1:0];
        end
    end

    always_comb begin
        n_res = '0;
        n_res.palette_dropped  = ~r_active;
        n_res.tile_limit_error = 1'b1;
        if (!r_job.ignored) begin
            n_res.pixel_byte_address = r_job.byte_addr;
            n_res.alpha              = r_job.alpha;
            n_res.index_address      = r_job.idx_addr;
            n_res.tile_end           = r_job.tile_end;
            n_res.tile_limit_error   = r_job.limit;
            if (r_hit) begin
                n_res.palette_index = r_ptr[7:0];
                n_res.index_valid   = 1'b1;
            end else if (w_append) begin
                n_res.palette_index = r_count[7:0];
                n_res.index_valid   = 1'b1;
                n_res.new_color     = 1'b1;
            end else if (w_overflow) begin
                n_res.palette_dropped = 1'b1;
            end
        end
    end

    tapb_ram #(.Width(24), .Depth(tapb_pkg::PaletteEntries)) u_pal (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ptr    <= '0;
            r_active <= 1'b1;
            r_seeded <= 1'b0;
            r_valid  <= 1'b0;
            r_res    <= '0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_hit <= 1'b0;
                        if (i_job.ignored) begin
                            r_state <= S_DONE;
                        end else if (!r_seeded) begin
                            r_seeded <= 1'b1;
                            if (i_trans_enable) begin
                                r_count <= tapb_pkg::CntW'(1);
                                r_state <= S_SEED;
                            end else begin
                                r_ptr   <= r_count;
                                r_state <= S_READ;
                            end
                        end else begin
                            r_ptr   <= r_count;
                            r_state <= S_READ;
                        end
                    end
                end
                S_SEED: begin
                    r_ptr   <= r_count;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (!r_active || r_ptr == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ptr   <= r_ptr - 1'b1;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_rdata == r_job.color) begin
                        r_hit   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        r_res   <= n_res;
                        if (w_append) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (w_overflow) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/tile_atlas_palette_builder_unit.sv
// ----------------------------------------------------------------------------
// tile_atlas_palette_builder_unit
// channel  | dir | tdata fields (low bit up)
// s_axis   | in  | red, green, blue
// m_axis   | out | pixel_byte_address, alpha, index_address, palette_index,
//          |     | index_valid, palette_dropped, new_color, tile_end,
//          |     | tile_limit_error
// cfg      | in  | i_cfg_we, i_cfg_index, i_cfg_data
// a result word follows its pixel through front, queue and back; the back
// reads the palette ram entry by entry, newest first. the front works out
// addresses in S_M1 to S_M4 and takes no new pixel until its job is handed
// on; a two-word queue lets it run ahead. reset is synchronous, active low.
// a stalled output word holds and stalls the back, then the queue and input.
// ----------------------------------------------------------------------------
module tile_atlas_palette_builder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // fields as listed above
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    logic        r_trans_enable;
    logic [23:0] r_trans_color;
    logic [11:0] r_tiles_across;
    logic [6:0]  r_tile_width, r_tile_height;

    logic           w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;
    tapb_pkg::t_job w_fjob, w_bjob;
    tapb_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_enable <= 1'b0;
            r_trans_color  <= '0;
            r_tiles_across <= 12'd40;
            r_tile_width   <= 7'd16;
            r_tile_height  <= 7'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tapb_pkg::RegTransEnable: r_trans_enable <= i_cfg_data[0];
                tapb_pkg::RegTransColor:  r_trans_color  <= i_cfg_data;
                tapb_pkg::RegTilesAcross: r_tiles_across <= i_cfg_data[11:0];
                tapb_pkg::RegTileWidth:   r_tile_width   <= i_cfg_data[6:0];
                tapb_pkg::RegTileHeight:  r_tile_height  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    tapb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_color({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
        .i_trans_enable(r_trans_enable), .i_trans_color(r_trans_color),
        .i_tiles_across(r_tiles_across), .i_tile_width(r_tile_width),
        .i_tile_height(r_tile_height),
        .o_job_valid(w_fj_valid), .i_job_ready(w_fj_ready), .o_job(w_fjob)
    );

    tapb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fj_valid), .o_ready(w_fj_ready), .i_data(w_fjob),
        .o_valid(w_bj_valid), .i_ready(w_bj_ready), .o_data(w_bjob)
    );

    tapb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_trans_enable(r_trans_enable), .i_trans_color(r_trans_color),
        .i_job_valid(w_bj_valid), .o_job_ready(w_bj_ready), .i_job(w_bjob),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(w_res)
    );

    assign m_axis_tdata = {3'b000, w_res.tile_limit_error, w_res.tile_end,
                           w_res.new_color, w_res.palette_dropped, w_res.index_valid,
                           w_res.palette_index, w_res.index_address, w_res.alpha,
                           w_res.pixel_byte_address};
endmodule

FILE: rtl/tapb_checker.sv
// ----------------------------------------------------------------------------
// tapb_checker
// port-level checks on the tile atlas palette builder
// ----------------------------------------------------------------------------
`include "tile_atlas_palette_builder_unit_defines.svh"
module tapb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    `TAPB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `TAPB_ASSERT_NEXT(a_drop_sticky, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tdata[65], !m_axis_tvalid || m_axis_tdata[65])
    `TAPB_ASSERT_IMP(a_new_has_valid, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[66], m_axis_tdata[64])
    `TAPB_ASSERT_IMP(a_dropped_no_idx, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[65], !m_axis_tdata[64])
endmodule

bind tile_atlas_palette_builder_unit tapb_checker u_tapb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

FILE: bench/tile_atlas_palette_builder_unit_test.sv
// ----------------------------------------------------------------------------
// tile_atlas_palette_builder_unit_test
// self-checking bench for the tile atlas palette builder: pixels are streamed
// through several register settings and idling phases, each result word is
// compared field by field with a local prediction of address, alpha, palette
// and tile-limit behaviour
// ----------------------------------------------------------------------------
module tile_atlas_palette_builder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;
    localparam int SettleCycles  = 600;
    localparam int HoldCycles    = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = tapb_pkg::RegTransEnable;
    logic [23:0] i_cfg_data = '0;

    tile_atlas_palette_builder_unit u_dut (.*);

    // pixel words waiting to be sent, expected result words
    logic [23:0]       pixel_queue[$];
    tapb_pkg::t_result result_queue[$];
    int          error_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    logic [23:0] colour_pool[48];

    // predictor copy of registers and state
    bit          pr_trans_en = 1'b0;
    logic [23:0] pr_trans_colour = '0;
    logic [11:0] pr_across = 12'd40;
    logic [6:0]  pr_width = 7'd16;
    logic [6:0]  pr_height = 7'd16;
    logic [23:0] pal_colours[tapb_pkg::PaletteEntries];
    int unsigned pal_fill = 0;
    bit          pal_live = 1'b1;
    bit          pal_seeded = 1'b0;
    int unsigned col_pos = 0, row_pos = 0, atlas_col = 0, atlas_row = 0;
    int unsigned tiles_done = 0;
    bit          at_limit = 1'b0;

    function automatic int unsigned clamp_side(int unsigned v);
        if (v < 1) return 1;
        if (v > tapb_pkg::MaxTileSide) return tapb_pkg::MaxTileSide;
        return v;
    endfunction

    function automatic tapb_pkg::t_result predict_pixel(logic [23:0] word);
        tapb_pkg::t_result r;
        logic [23:0]     colour;
        int unsigned     tw, th, across, pw;
        int              hit;
        longint unsigned prow, baddr, iaddr;
        r = '0;
        if (at_limit) begin
            r.palette_dropped  = !pal_live;
            r.tile_limit_error = 1'b1;
            return r;
        end
        colour = {word[7:0], word[15:8], word[23:16]};
        tw = clamp_side(32'(pr_width));
        th = clamp_side(32'(pr_height));
        across = (pr_across < 1) ? 1 :
                 ((pr_across > tapb_pkg::AcrossMax) ? tapb_pkg::AcrossMax : 32'(pr_across));
        pw = pr_trans_en ? 4 : 3;
        if (!pal_seeded) begin
            pal_seeded = 1'b1;
            if (pr_trans_en) begin
                pal_colours[0] = pr_trans_colour;
                pal_fill = 1;
            end
        end
        prow  = longint'(atlas_row) * th + row_pos;
        baddr = (prow * across * tw + longint'(atlas_col) * tw + col_pos) * pw;
        iaddr = (prow * across + atlas_col) * tw + col_pos;
        r.alpha = (pr_trans_en && colour == pr_trans_colour) ? 8'd0 : 8'd255;
        if (pal_live) begin
            hit = -1;
            for (int i = int'(pal_fill) - 1; i >= 0; i--) begin
                if (pal_colours[i] == colour) begin
                    hit = i;
                    break;
                end
            end
            if (hit >= 0) begin
                r.palette_index = hit[7:0];
                r.index_valid   = 1'b1;
            end else if (pal_fill < tapb_pkg::PaletteEntries) begin
                r.palette_index = pal_fill[7:0];
                pal_colours[pal_fill] = colour;
                pal_fill++;
                r.index_valid = 1'b1;
                r.new_color   = 1'b1;
            end else begin
                pal_live = 1'b0;
            end
        end
        if (col_pos + 1 >= tw) begin
            col_pos = 0;
            if (row_pos + 1 >= th) begin
                row_pos = 0;
                r.tile_end = 1'b1;
                atlas_col++;
                if (atlas_col >= across) begin
                    atlas_col = 0;
                    atlas_row = (atlas_row + 1) & 11'h7ff;
                end
                tiles_done = (tiles_done + 1) & 12'hfff;
                if (tiles_done >= tapb_pkg::MaxTiles) at_limit = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        r.pixel_byte_address = baddr[24:0];
        r.index_address      = iaddr[22:0];
        r.palette_dropped    = !pal_live;
        r.tile_limit_error   = at_limit;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", field, got, want);
        error_count++;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                result_queue.push_back(predict_pixel(s_axis_tdata));
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        tapb_pkg::t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.pixel_byte_address = m_axis_tdata[24:0];
                got.alpha              = m_axis_tdata[32:25];
                got.index_address      = m_axis_tdata[55:33];
                got.palette_index      = m_axis_tdata[63:56];
                got.index_valid        = m_axis_tdata[64];
                got.palette_dropped    = m_axis_tdata[65];
                got.new_color          = m_axis_tdata[66];
                got.tile_end           = m_axis_tdata[67];
                got.tile_limit_error   = m_axis_tdata[68];
                if (result_queue.size() == 0) begin
                    $display("unexpected result word %0h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (got.pixel_byte_address != want.pixel_byte_address)
                        report_mismatch("pixel_byte_address", 32'(got.pixel_byte_address),
                                        32'(want.pixel_byte_address));
                    if (got.alpha != want.alpha)
                        report_mismatch("alpha", 32'(got.alpha), 32'(want.alpha));
                    if (got.index_address != want.index_address)
                        report_mismatch("index_address", 32'(got.index_address),
                                        32'(want.index_address));
                    if (got.palette_index != want.palette_index)
                        report_mismatch("palette_index", 32'(got.palette_index),
                                        32'(want.palette_index));
                    if (got.index_valid != want.index_valid)
                        report_mismatch("index_valid", 32'(got.index_valid),
                                        32'(want.index_valid));
                    if (got.palette_dropped != want.palette_dropped)
                        report_mismatch("palette_dropped", 32'(got.palette_dropped),
                                        32'(want.palette_dropped));
                    if (got.new_color != want.new_color)
                        report_mismatch("new_color", 32'(got.new_color), 32'(want.new_color));
                    if (got.tile_end != want.tile_end)
                        report_mismatch("tile_end", 32'(got.tile_end), 32'(want.tile_end));
                    if (got.tile_limit_error != want.tile_limit_error)
                        report_mismatch("tile_limit_error", 32'(got.tile_limit_error),
                                        32'(want.tile_limit_error));
                end
            end
            if (hold_off_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HoldCycles;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // watchdog on cycles with no word accepted
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            tapb_pkg::RegTransEnable: pr_trans_en = value[0];
            tapb_pkg::RegTransColor:  pr_trans_colour = value;
            tapb_pkg::RegTilesAcross: pr_across = value[11:0];
            tapb_pkg::RegTileWidth:   pr_width = value[6:0];
            tapb_pkg::RegTileHeight:  pr_height = value[6:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() > 0 || s_axis_tvalid || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_pressure(int idle_pct, int stall_pct);
        @(posedge i_clk);
        sender_idle_pct    <= idle_pct;
        receiver_stall_pct <= stall_pct;
    endtask

    function automatic logic [23:0] to_word(logic [23:0] rgb);
        return {rgb[7:0], rgb[15:8], rgb[23:16]};
    endfunction

    task automatic queue_pool_pixels(int count, logic [23:0] trans_rgb);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                pixel_queue.push_back(to_word(trans_rgb));
            else
                pixel_queue.push_back(to_word(colour_pool[$urandom_range(47)]));
        end
    endtask

    initial begin
        foreach (colour_pool[i]) colour_pool[i] = 24'($urandom());
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // seeded palette, small tiles, directed colours
        write_reg(tapb_pkg::RegTransEnable, 24'd1);
        write_reg(tapb_pkg::RegTransColor, 24'h123456);
        write_reg(tapb_pkg::RegTilesAcross, 24'd3);
        write_reg(tapb_pkg::RegTileWidth, 24'd2);
        write_reg(tapb_pkg::RegTileHeight, 24'd3);
        pixel_queue.push_back(to_word(24'h123456));
        pixel_queue.push_back(to_word(24'h000000));
        pixel_queue.push_back(to_word(24'hffffff));
        pixel_queue.push_back(to_word(24'h000000));
        pixel_queue.push_back(to_word(24'hff0000));
        pixel_queue.push_back(to_word(24'h00ff00));
        pixel_queue.push_back(to_word(24'h0000ff));
        pixel_queue.push_back(to_word(24'h123456));
        pixel_queue.push_back(to_word(24'h123457));
        pixel_queue.push_back(to_word(24'hffffff));
        pixel_queue.push_back(to_word(24'haa55aa));
        pixel_queue.push_back(to_word(24'h55aa55));
        for (int i = 0; i < 8; i++) pixel_queue.push_back(to_word(24'h000000));
        wait_idle();

        // widest atlas, largest tiles, long receiver hold-off
        write_reg(tapb_pkg::RegTilesAcross, 24'd2048);
        write_reg(tapb_pkg::RegTileWidth, 24'd64);
        write_reg(tapb_pkg::RegTileHeight, 24'd64);
        set_pressure(64, 0);
        queue_pool_pixels(150, 24'h123456);
        @(posedge i_clk);
        hold_off_req <= 1'b1;
        wait_idle();

        // rgb layout, narrow tiles one row high
        write_reg(tapb_pkg::RegTransEnable, 24'd0);
        write_reg(tapb_pkg::RegTilesAcross, 24'd1);
        write_reg(tapb_pkg::RegTileWidth, 24'd5);
        write_reg(tapb_pkg::RegTileHeight, 24'd1);
        set_pressure(0, 64);
        queue_pool_pixels(150, 24'h123456);
        wait_idle();

        // out-of-range sizes, new transparent colour
        write_reg(tapb_pkg::RegTransEnable, 24'd1);
        write_reg(tapb_pkg::RegTransColor, colour_pool[5]);
        write_reg(tapb_pkg::RegTilesAcross, 24'd0);
        write_reg(tapb_pkg::RegTileWidth, 24'd0);
        write_reg(tapb_pkg::RegTileHeight, 24'd127);
        set_pressure(36, 36);
        queue_pool_pixels(150, colour_pool[5]);
        wait_idle();

        // unrestricted colours until the palette overflows
        write_reg(tapb_pkg::RegTransColor, 24'hffffff);
        write_reg(tapb_pkg::RegTilesAcross, 24'd4095);
        write_reg(tapb_pkg::RegTileWidth, 24'd7);
        write_reg(tapb_pkg::RegTileHeight, 24'd3);
        set_pressure(0, 0);
        for (int i = 0; i < 300; i++) pixel_queue.push_back(24'($urandom()));
        pixel_queue.push_back(24'hffffff);
        pixel_queue.push_back(24'h000000);
        wait_idle();

        // one-pixel tiles with a dropped palette
        write_reg(tapb_pkg::RegTilesAcross, 24'd1);
        write_reg(tapb_pkg::RegTileWidth, 24'd1);
        write_reg(tapb_pkg::RegTileHeight, 24'd1);
        set_pressure(36, 36);
        for (int i = 0; i < 278; i++) pixel_queue.push_back(24'($urandom()));
        while (pixel_queue.size() > 0 || s_axis_tvalid || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tapb_pkg.sv
rtl/tapb_ram.sv
rtl/tapb_front.sv
rtl/tapb_queue.sv
rtl/tapb_back.sv
rtl/tile_atlas_palette_builder_unit.sv
rtl/tapb_checker.sv
bench/tile_atlas_palette_builder_unit_test.sv
